[rtl/wrsa_pkg.sv]
// shared types, constants and helper functions of the weighted rate share allocator
package wrsa_pkg;

  localparam int MAX_FLOWS = 8;
  localparam int RATE_BITS = 32;
  localparam int PRIO_BITS = 8;
  localparam int SUM_BITS  = RATE_BITS + 8;
  localparam int SLOT_BITS = (MAX_FLOWS > 1) ? $clog2(MAX_FLOWS) : 1;
  localparam int PSUM_BITS = $clog2(MAX_FLOWS * ((1 << PRIO_BITS) - 1) + 1);
  localparam int PROD_BITS = SUM_BITS + PRIO_BITS;
  localparam int DCNT_BITS = $clog2(PROD_BITS);
  localparam int RND_BITS  = $clog2(MAX_FLOWS + 1);
  localparam int CNT_BITS  = $clog2(MAX_FLOWS + 1);

  typedef enum logic [1:0] {
    CMD_REGISTER   = 2'd0,
    CMD_UNREGISTER = 2'd1,
    CMD_UPDATE     = 2'd2,
    CMD_NONE       = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_NOREG = 2'd2,
    STS_RSVD  = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_REGISTER,
    OP_NOREG,
    OP_UNREG,
    OP_UPDATE,
    OP_SINGLE,
    OP_INIT,
    OP_ROUND,
    OP_END_ROUND,
    OP_SKIP,
    OP_MUL,
    OP_APPLY,
    OP_EMIT
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SINGLE,
    ST_INIT,
    ST_ROUND,
    ST_VISIT,
    ST_MUL,
    ST_DIV,
    ST_APPLY,
    ST_EMIT
  } state_t;

  typedef struct packed {
    op_t op;
  } ctl_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic slot_ok;
    logic single;
    logic idx_last;
    logic round_go;
    logic eligible;
    logic idx_valid;
    logic idx_final;
    logic out_free;
    logic div_done;
  } dp_status_t;

  function automatic logic [SUM_BITS-1:0] sat_add(input logic [SUM_BITS-1:0] a,
                                                  input logic [RATE_BITS-1:0] b);
    logic [SUM_BITS:0] s;
    s = {1'b0, a} + (SUM_BITS + 1)'(b);
    return s[SUM_BITS] ? {SUM_BITS{1'b1}} : s[SUM_BITS-1:0];
  endfunction

  function automatic logic [SUM_BITS-1:0] sat_sub(input logic [SUM_BITS-1:0] a,
                                                  input logic [RATE_BITS-1:0] b);
    logic [SUM_BITS-1:0] bw;
    bw = SUM_BITS'(b);
    return (a > bw) ? (a - bw) : '0;
  endfunction

endpackage

[rtl/weighted_rate_share_allocator_top.sv]
// top level of the weighted rate share allocator
// Usage: one input channel (in_valid / in_stall) carries commands: register a
// flow, unregister a flow, or update a flow's rate from congestion control.
// The result channel (out_valid / out_stall) returns one transfer per result;
// out_last marks the final result of a command. Register, unregister and
// error cases give one result; an update of one of several flows gives one
// result per registered flow in slot order.
// Simple commands are latched on acceptance; their result is then loaded into
// the result register once it is free. An update first visits every slot for
// setup, then runs up to MAX_FLOWS rounds over the slots; each eligible slot
// is multiplied, divided by the shared bit-serial divider and applied.
// One command is in work at a time; in_stall is high from acceptance until the
// command's last result is loaded.
// The result register lets the next command be accepted while a result waits.
// When the receiver stalls, the result holds and emission waits.
// Reset (synchronous, active low) empties the table and clears the rate sum.
module weighted_rate_share_allocator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [2:0]  in_flow_slot,
  input  logic [31:0] in_cc_rate,
  input  logic [31:0] in_rate_cap,
  input  logic [7:0]  in_priority_req,
  input  logic [31:0] in_initial_rate,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [2:0]  out_result_slot,
  output logic [31:0] out_allocated_rate,
  output logic        out_last
);

  wrsa_pkg::ctl_cmd_t   ctl;
  wrsa_pkg::dp_status_t sts;
  logic                 idle;
  logic                 accept;

  assign in_stall = !idle;
  assign accept   = in_valid && idle;

  wrsa_ctl u_ctl (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .sts    (sts),
    .ctl    (ctl),
    .idle   (idle)
  );

  wrsa_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctl                (ctl),
    .sts                (sts),
    .in_command         (in_command),
    .in_flow_slot       (in_flow_slot),
    .in_cc_rate         (in_cc_rate),
    .in_rate_cap        (in_rate_cap),
    .in_priority_req    (in_priority_req),
    .in_initial_rate    (in_initial_rate),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_result_slot    (out_result_slot),
    .out_allocated_rate (out_allocated_rate),
    .out_last           (out_last)
  );

endmodule

[rtl/wrsa_div.sv]
// restoring divider, one quotient bit per cycle
module wrsa_div (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [wrsa_pkg::PROD_BITS-1:0] dividend,
  input  logic [wrsa_pkg::PSUM_BITS-1:0] divisor,
  output logic                           done,
  output logic [wrsa_pkg::PROD_BITS-1:0] quotient
);

  logic [wrsa_pkg::PROD_BITS-1:0] quo_r, quo_nxt;
  logic [wrsa_pkg::PSUM_BITS-1:0] rem_r, rem_nxt;
  logic [wrsa_pkg::PSUM_BITS-1:0] div_r, div_nxt;
  logic [wrsa_pkg::DCNT_BITS-1:0] cnt_r, cnt_nxt;
  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [wrsa_pkg::PSUM_BITS:0]   trial;
  logic [wrsa_pkg::PSUM_BITS:0]   diff;
  logic                           ge;

  always_comb begin
    trial    = {rem_r, quo_r[wrsa_pkg::PROD_BITS-1]};
    ge       = trial >= {1'b0, div_r};
    diff     = trial - {1'b0, div_r};
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      quo_nxt  = dividend;
      rem_nxt  = '0;
      div_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      quo_nxt = {quo_r[wrsa_pkg::PROD_BITS-2:0], ge};
      rem_nxt = ge ? diff[wrsa_pkg::PSUM_BITS-1:0] : trial[wrsa_pkg::PSUM_BITS-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == wrsa_pkg::DCNT_BITS'(wrsa_pkg::PROD_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !busy_r)
    else $error("divider done while busy");
`endif

endmodule

[rtl/wrsa_dp.sv]
// datapath: flow table, rate sum, share distribution and result register
module wrsa_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  wrsa_pkg::ctl_cmd_t          ctl,
  output wrsa_pkg::dp_status_t        sts,
  input  logic [1:0]                  in_command,
  input  logic [2:0]                  in_flow_slot,
  input  logic [31:0]                 in_cc_rate,
  input  logic [31:0]                 in_rate_cap,
  input  logic [7:0]                  in_priority_req,
  input  logic [31:0]                 in_initial_rate,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [1:0]                  out_status,
  output logic [2:0]                  out_result_slot,
  output logic [31:0]                 out_allocated_rate,
  output logic                        out_last
);

  localparam int MF = wrsa_pkg::MAX_FLOWS;
  localparam int RB = wrsa_pkg::RATE_BITS;
  localparam int SB = wrsa_pkg::SUM_BITS;
  localparam int LB = wrsa_pkg::SLOT_BITS;

  logic                           valid_r [MF];
  logic                           valid_nxt [MF];
  logic [wrsa_pkg::PRIO_BITS-1:0] prio_r [MF];
  logic [wrsa_pkg::PRIO_BITS-1:0] prio_nxt [MF];
  logic [RB-1:0]                  share_r [MF];
  logic [RB-1:0]                  share_nxt [MF];
  logic [RB-1:0]                  cap_r [MF];
  logic [RB-1:0]                  cap_nxt [MF];
  logic [SB-1:0]                  sum_r, sum_nxt;

  wrsa_pkg::cmd_t                 cmd_r, cmd_nxt;
  logic [LB-1:0]                  slot_r, slot_nxt;
  logic [RB-1:0]                  cc_r, cc_nxt;
  logic [RB-1:0]                  want_r, want_nxt;
  logic [wrsa_pkg::PRIO_BITS-1:0] preq_r, preq_nxt;
  logic [RB-1:0]                  init_r, init_nxt;

  logic [LB-1:0]                  idx_r, idx_nxt;
  logic [wrsa_pkg::RND_BITS-1:0]  round_r, round_nxt;
  logic [wrsa_pkg::PSUM_BITS-1:0] psum_r, psum_nxt;
  logic [SB-1:0]                  left_r, left_nxt;
  logic [SB-1:0]                  agg_r, agg_nxt;

  logic                           ov_r, ov_nxt;
  wrsa_pkg::status_t              ost_r, ost_nxt;
  logic [2:0]                     oslot_r, oslot_nxt;
  logic [31:0]                    orate_r, orate_nxt;
  logic                           olast_r, olast_nxt;

  logic                           free_found;
  logic [LB-1:0]                  free_idx;
  logic [wrsa_pkg::CNT_BITS-1:0]  vcount;
  logic                           above;
  logic                           out_free;
  logic                           div_start;
  logic                           div_done;
  logic [wrsa_pkg::PROD_BITS-1:0] div_q;
  logic [wrsa_pkg::PROD_BITS-1:0] product;
  logic [wrsa_pkg::PROD_BITS-1:0] q_eff;
  logic                           q_ge_cap;
  logic [RB-1:0]                  single_rate;

  assign out_free  = !ov_r || !out_stall;
  assign product   = wrsa_pkg::PROD_BITS'(left_r) * wrsa_pkg::PROD_BITS'(prio_r[idx_r]);
  assign div_start = (ctl.op == wrsa_pkg::OP_MUL);
  assign q_eff     = (psum_r == '0) ? '0 : div_q;
  assign q_ge_cap  = q_eff >= wrsa_pkg::PROD_BITS'(cap_r[idx_r]);
  assign single_rate = (sum_r > SB'({RB{1'b1}})) ? {RB{1'b1}} : sum_r[RB-1:0];

  wrsa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (product),
    .divisor  (psum_r),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    vcount     = '0;
    above      = 1'b0;
    for (int i = MF - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_found = 1'b1;
        free_idx   = LB'(i);
      end
    end
    for (int i = 0; i < MF; i++) begin
      vcount = vcount + wrsa_pkg::CNT_BITS'(valid_r[i]);
      if ((LB + 1)'(i) > {1'b0, idx_r} && valid_r[i]) begin
        above = 1'b1;
      end
    end
  end

  always_comb begin
    sts.cmd       = cmd_r;
    sts.slot_ok   = valid_r[slot_r];
    sts.single    = (vcount == wrsa_pkg::CNT_BITS'(1));
    sts.idx_last  = (idx_r == LB'(MF - 1));
    sts.round_go  = (round_r < wrsa_pkg::RND_BITS'(MF)) && (psum_r != '0) &&
                    ({1'b0, left_r} > ({1'b0, agg_r} + (SB + 1)'(1)));
    sts.eligible  = valid_r[idx_r] && (share_r[idx_r] < cap_r[idx_r]);
    sts.idx_valid = valid_r[idx_r];
    sts.idx_final = !above;
    sts.out_free  = out_free;
    sts.div_done  = div_done;
  end

  always_comb begin
    valid_nxt = valid_r;
    prio_nxt  = prio_r;
    share_nxt = share_r;
    cap_nxt   = cap_r;
    sum_nxt   = sum_r;
    cmd_nxt   = cmd_r;
    slot_nxt  = slot_r;
    cc_nxt    = cc_r;
    want_nxt  = want_r;
    preq_nxt  = preq_r;
    init_nxt  = init_r;
    idx_nxt   = idx_r;
    round_nxt = round_r;
    psum_nxt  = psum_r;
    left_nxt  = left_r;
    agg_nxt   = agg_r;
    ov_nxt    = ov_r && out_stall;
    ost_nxt   = ost_r;
    oslot_nxt = oslot_r;
    orate_nxt = orate_r;
    olast_nxt = olast_r;
    unique case (ctl.op)
      wrsa_pkg::OP_NONE, wrsa_pkg::OP_MUL: begin
      end
      wrsa_pkg::OP_LATCH: begin
        cmd_nxt  = wrsa_pkg::cmd_t'(in_command);
        slot_nxt = LB'(in_flow_slot);
        cc_nxt   = RB'(in_cc_rate);
        want_nxt = RB'(in_rate_cap);
        preq_nxt = in_priority_req;
        init_nxt = RB'(in_initial_rate);
      end
      wrsa_pkg::OP_REGISTER: begin
        ov_nxt    = 1'b1;
        olast_nxt = 1'b1;
        if (free_found) begin
          valid_nxt[free_idx] = 1'b1;
          prio_nxt[free_idx]  = preq_r;
          share_nxt[free_idx] = init_r;
          cap_nxt[free_idx]   = want_r;
          sum_nxt             = wrsa_pkg::sat_add(sum_r, init_r);
          ost_nxt             = wrsa_pkg::STS_OK;
          oslot_nxt           = 3'(free_idx);
          orate_nxt           = 32'(init_r);
        end else begin
          ost_nxt   = wrsa_pkg::STS_FULL;
          oslot_nxt = '0;
          orate_nxt = '0;
        end
      end
      wrsa_pkg::OP_NOREG: begin
        ov_nxt    = 1'b1;
        ost_nxt   = wrsa_pkg::STS_NOREG;
        oslot_nxt = 3'(slot_r);
        orate_nxt = '0;
        olast_nxt = 1'b1;
      end
      wrsa_pkg::OP_UNREG: begin
        valid_nxt[slot_r] = 1'b0;
        sum_nxt   = wrsa_pkg::sat_sub(sum_r, share_r[slot_r]);
        ov_nxt    = 1'b1;
        ost_nxt   = wrsa_pkg::STS_OK;
        oslot_nxt = 3'(slot_r);
        orate_nxt = '0;
        olast_nxt = 1'b1;
      end
      wrsa_pkg::OP_UPDATE: begin
        cap_nxt[slot_r] = want_r;
        sum_nxt  = wrsa_pkg::sat_sub(wrsa_pkg::sat_add(sum_r, cc_r), share_r[slot_r]);
        idx_nxt  = '0;
        psum_nxt = '0;
      end
      wrsa_pkg::OP_SINGLE: begin
        share_nxt[slot_r] = single_rate;
        ov_nxt    = 1'b1;
        ost_nxt   = wrsa_pkg::STS_OK;
        oslot_nxt = 3'(slot_r);
        orate_nxt = 32'(single_rate);
        olast_nxt = 1'b1;
      end
      wrsa_pkg::OP_INIT: begin
        if (valid_r[idx_r]) begin
          psum_nxt         = psum_r + wrsa_pkg::PSUM_BITS'(prio_r[idx_r]);
          share_nxt[idx_r] = '0;
        end
        idx_nxt   = idx_r + 1'b1;
        left_nxt  = sum_r;
        agg_nxt   = '0;
        round_nxt = '0;
      end
      wrsa_pkg::OP_ROUND: begin
        agg_nxt   = '0;
        idx_nxt   = '0;
        round_nxt = round_r + 1'b1;
      end
      wrsa_pkg::OP_END_ROUND: begin
        idx_nxt = '0;
      end
      wrsa_pkg::OP_SKIP: begin
        idx_nxt = idx_r + 1'b1;
      end
      wrsa_pkg::OP_APPLY: begin
        if (q_ge_cap) begin
          left_nxt         = left_r - SB'(cap_r[idx_r]);
          share_nxt[idx_r] = cap_r[idx_r];
          psum_nxt         = psum_r - wrsa_pkg::PSUM_BITS'(prio_r[idx_r]);
        end else begin
          share_nxt[idx_r] = q_eff[RB-1:0];
          agg_nxt          = agg_r + q_eff[SB-1:0];
        end
        idx_nxt = idx_r + 1'b1;
      end
      wrsa_pkg::OP_EMIT: begin
        ov_nxt    = 1'b1;
        ost_nxt   = wrsa_pkg::STS_OK;
        oslot_nxt = 3'(idx_r);
        orate_nxt = 32'(share_r[idx_r]);
        olast_nxt = !above;
        idx_nxt   = idx_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prio_r  <= prio_nxt;
    share_r <= share_nxt;
    cap_r   <= cap_nxt;
    cmd_r   <= cmd_nxt;
    slot_r  <= slot_nxt;
    cc_r    <= cc_nxt;
    want_r  <= want_nxt;
    preq_r  <= preq_nxt;
    init_r  <= init_nxt;
    idx_r   <= idx_nxt;
    round_r <= round_nxt;
    psum_r  <= psum_nxt;
    left_r  <= left_nxt;
    agg_r   <= agg_nxt;
    ost_r   <= ost_nxt;
    oslot_r <= oslot_nxt;
    orate_r <= orate_nxt;
    olast_r <= olast_nxt;
    if (!rst_n) begin
      for (int i = 0; i < MF; i++) begin
        valid_r[i] <= 1'b0;
      end
      sum_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      sum_r   <= sum_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign out_valid          = ov_r;
  assign out_status         = ost_r;
  assign out_result_slot    = oslot_r;
  assign out_allocated_rate = orate_r;
  assign out_last           = olast_r;

`ifndef SYNTHESIS
  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == wrsa_pkg::OP_EMIT || ctl.op == wrsa_pkg::OP_SINGLE ||
     ctl.op == wrsa_pkg::OP_NOREG || ctl.op == wrsa_pkg::OP_UNREG ||
     ctl.op == wrsa_pkg::OP_REGISTER) |-> out_free)
    else $error("result overwritten while stalled");
  a_round_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == wrsa_pkg::OP_ROUND) |-> (round_r < wrsa_pkg::RND_BITS'(MF)))
    else $error("round count beyond bound");
  a_apply_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == wrsa_pkg::OP_APPLY) |-> div_done)
    else $error("share applied before quotient ready");
`endif

endmodule

[rtl/wrsa_ctl.sv]
// controller state machine sequencing commands, rounds and result transfers
module wrsa_ctl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept,
  input  wrsa_pkg::dp_status_t sts,
  output wrsa_pkg::ctl_cmd_t   ctl,
  output logic                 idle
);

  wrsa_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wrsa_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl.op    = wrsa_pkg::OP_NONE;
    unique case (state_r)
      wrsa_pkg::ST_IDLE: begin
        if (accept) begin
          ctl.op    = wrsa_pkg::OP_LATCH;
          state_nxt = wrsa_pkg::ST_EXEC;
        end
      end
      wrsa_pkg::ST_EXEC: begin
        priority if (sts.cmd == wrsa_pkg::CMD_NONE) begin
          state_nxt = wrsa_pkg::ST_IDLE;
        end else if (sts.cmd == wrsa_pkg::CMD_REGISTER) begin
          if (sts.out_free) begin
            ctl.op    = wrsa_pkg::OP_REGISTER;
            state_nxt = wrsa_pkg::ST_IDLE;
          end
        end else if (!sts.slot_ok) begin
          if (sts.out_free) begin
            ctl.op    = wrsa_pkg::OP_NOREG;
            state_nxt = wrsa_pkg::ST_IDLE;
          end
        end else if (sts.cmd == wrsa_pkg::CMD_UNREGISTER) begin
          if (sts.out_free) begin
            ctl.op    = wrsa_pkg::OP_UNREG;
            state_nxt = wrsa_pkg::ST_IDLE;
          end
        end else begin
          ctl.op    = wrsa_pkg::OP_UPDATE;
          state_nxt = sts.single ? wrsa_pkg::ST_SINGLE : wrsa_pkg::ST_INIT;
        end
      end
      wrsa_pkg::ST_SINGLE: begin
        if (sts.out_free) begin
          ctl.op    = wrsa_pkg::OP_SINGLE;
          state_nxt = wrsa_pkg::ST_IDLE;
        end
      end
      wrsa_pkg::ST_INIT: begin
        ctl.op = wrsa_pkg::OP_INIT;
        if (sts.idx_last) begin
          state_nxt = wrsa_pkg::ST_ROUND;
        end
      end
      wrsa_pkg::ST_ROUND: begin
        if (sts.round_go) begin
          ctl.op    = wrsa_pkg::OP_ROUND;
          state_nxt = wrsa_pkg::ST_VISIT;
        end else begin
          ctl.op    = wrsa_pkg::OP_END_ROUND;
          state_nxt = wrsa_pkg::ST_EMIT;
        end
      end
      wrsa_pkg::ST_VISIT: begin
        if (sts.eligible) begin
          state_nxt = wrsa_pkg::ST_MUL;
        end else begin
          ctl.op = wrsa_pkg::OP_SKIP;
          if (sts.idx_last) begin
            state_nxt = wrsa_pkg::ST_ROUND;
          end
        end
      end
      wrsa_pkg::ST_MUL: begin
        ctl.op    = wrsa_pkg::OP_MUL;
        state_nxt = wrsa_pkg::ST_DIV;
      end
      wrsa_pkg::ST_DIV: begin
        if (sts.div_done) begin
          state_nxt = wrsa_pkg::ST_APPLY;
        end
      end
      wrsa_pkg::ST_APPLY: begin
        ctl.op    = wrsa_pkg::OP_APPLY;
        state_nxt = sts.idx_last ? wrsa_pkg::ST_ROUND : wrsa_pkg::ST_VISIT;
      end
      wrsa_pkg::ST_EMIT: begin
        if (!sts.idx_valid) begin
          ctl.op = wrsa_pkg::OP_SKIP;
        end else if (sts.out_free) begin
          ctl.op = wrsa_pkg::OP_EMIT;
          if (sts.idx_final) begin
            state_nxt = wrsa_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = wrsa_pkg::ST_IDLE;
      end
    endcase
  end

  assign idle = (state_r == wrsa_pkg::ST_IDLE);

`ifndef SYNTHESIS
  a_apply_from_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == wrsa_pkg::ST_APPLY) |-> ($past(state_r) == wrsa_pkg::ST_DIV))
    else $error("apply entered without division");
`endif

endmodule

[tb/sv/tb_top.sv]
// self-checking testbench of the weighted rate share allocator
`timescale 1ns / 100ps

module tb_top;

  localparam int SW = wrsa_pkg::SUM_BITS + 1;
  localparam int QW = wrsa_pkg::SUM_BITS + 9;

  typedef struct packed {
    wrsa_pkg::cmd_t command;
    logic [2:0]     flow_slot;
    logic [31:0]    cc_rate;
    logic [31:0]    rate_cap;
    logic [7:0]     priority_req;
    logic [31:0]    initial_rate;
  } flow_cmd_t;

  typedef struct packed {
    wrsa_pkg::status_t status;
    logic [2:0]        result_slot;
    logic [31:0]       allocated_rate;
    logic              last;
  } alloc_res_t;

  localparam longint CYCLE_LIMIT = 3000000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_command;
  logic [2:0]  in_flow_slot;
  logic [31:0] in_cc_rate;
  logic [31:0] in_rate_cap;
  logic [7:0]  in_priority_req;
  logic [31:0] in_initial_rate;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [2:0]  out_result_slot;
  logic [31:0] out_allocated_rate;
  logic        out_last;

  weighted_rate_share_allocator_top i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_command(in_command), .in_flow_slot(in_flow_slot),
    .in_cc_rate(in_cc_rate), .in_rate_cap(in_rate_cap),
    .in_priority_req(in_priority_req), .in_initial_rate(in_initial_rate),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_result_slot(out_result_slot),
    .out_allocated_rate(out_allocated_rate), .out_last(out_last)
  );

  // model of the flow table
  logic                          flow_valid [wrsa_pkg::MAX_FLOWS];
  logic [7:0]                    flow_prio  [wrsa_pkg::MAX_FLOWS];
  logic [SW-1:0]                 flow_share [wrsa_pkg::MAX_FLOWS];
  logic [SW-1:0]                 flow_cap   [wrsa_pkg::MAX_FLOWS];
  logic [wrsa_pkg::SUM_BITS-1:0] rate_sum;

  flow_cmd_t  pending_cmds[$];
  alloc_res_t expected_allocs[$];
  int  send_idle_pct;
  int  recv_stall_pct;
  int  hold_cycles;
  bit  pause_sender;
  bit  in_fire;
  int  errors;
  longint cycles;

  function automatic logic [wrsa_pkg::SUM_BITS-1:0] sum_plus(
      logic [wrsa_pkg::SUM_BITS-1:0] a, logic [31:0] b);
    logic [wrsa_pkg::SUM_BITS:0] s;
    s = {1'b0, a} + SW'(b);
    return s[wrsa_pkg::SUM_BITS] ? {wrsa_pkg::SUM_BITS{1'b1}} : s[wrsa_pkg::SUM_BITS-1:0];
  endfunction

  function automatic logic [wrsa_pkg::SUM_BITS-1:0] sum_minus(
      logic [wrsa_pkg::SUM_BITS-1:0] a, logic [31:0] b);
    return (a > wrsa_pkg::SUM_BITS'(b)) ? a - wrsa_pkg::SUM_BITS'(b) : '0;
  endfunction

  function automatic alloc_res_t mk_res(wrsa_pkg::status_t st, int slot, logic [31:0] r,
                                        bit l);
    alloc_res_t x;
    x.status = st;
    x.result_slot = slot[2:0];
    x.allocated_rate = r;
    x.last = l;
    return x;
  endfunction

  task automatic share_out_sum();
    logic [15:0]   prio_left;
    logic [SW-1:0] leftover;
    logic [SW-1:0] aggregate;
    logic [QW-1:0] q;
    prio_left = '0;
    leftover = SW'(rate_sum);
    aggregate = '0;
    for (int i = 0; i < wrsa_pkg::MAX_FLOWS; i++)
      if (flow_valid[i]) begin
        prio_left += 16'(flow_prio[i]);
        flow_share[i] = '0;
      end
    for (int rnd = 0; rnd < wrsa_pkg::MAX_FLOWS; rnd++) begin
      if (!(leftover > aggregate && leftover - aggregate > SW'(1) && prio_left != 16'd0))
        break;
      aggregate = '0;
      for (int i = 0; i < wrsa_pkg::MAX_FLOWS; i++) begin
        if (!flow_valid[i] || flow_share[i] >= flow_cap[i]) continue;
        q = (prio_left != 16'd0) ?
            (QW'(leftover) * QW'(flow_prio[i])) / QW'(prio_left) : '0;
        if (q >= QW'(flow_cap[i])) begin
          leftover -= flow_cap[i];
          flow_share[i] = flow_cap[i];
          prio_left -= 16'(flow_prio[i]);
        end else begin
          flow_share[i] = SW'(q);
          aggregate += SW'(q);
        end
      end
    end
  endtask

  task automatic predict_allocs(flow_cmd_t c);
    int k;
    int count;
    int n;
    k = wrsa_pkg::MAX_FLOWS;
    count = 0;
    n = 0;
    case (c.command)
      wrsa_pkg::CMD_REGISTER: begin
        for (int i = wrsa_pkg::MAX_FLOWS - 1; i >= 0; i--)
          if (!flow_valid[i]) k = i;
        if (k == wrsa_pkg::MAX_FLOWS) begin
          expected_allocs.push_back(mk_res(wrsa_pkg::STS_FULL, 0, 32'd0, 1'b1));
        end else begin
          flow_valid[k] = 1'b1;
          flow_prio[k] = c.priority_req;
          flow_share[k] = SW'(c.initial_rate);
          flow_cap[k] = SW'(c.rate_cap);
          rate_sum = sum_plus(rate_sum, c.initial_rate);
          expected_allocs.push_back(mk_res(wrsa_pkg::STS_OK, k, c.initial_rate, 1'b1));
        end
      end
      wrsa_pkg::CMD_NONE: ;
      default: begin
        k = int'(c.flow_slot);
        if (!flow_valid[k]) begin
          expected_allocs.push_back(mk_res(wrsa_pkg::STS_NOREG, k, 32'd0, 1'b1));
        end else if (c.command == wrsa_pkg::CMD_UNREGISTER) begin
          flow_valid[k] = 1'b0;
          rate_sum = sum_minus(rate_sum, flow_share[k][31:0]);
          expected_allocs.push_back(mk_res(wrsa_pkg::STS_OK, k, 32'd0, 1'b1));
        end else begin
          flow_cap[k] = SW'(c.rate_cap);
          rate_sum = sum_minus(sum_plus(rate_sum, c.cc_rate), flow_share[k][31:0]);
          for (int i = 0; i < wrsa_pkg::MAX_FLOWS; i++) count += int'(flow_valid[i]);
          if (count <= 1) begin
            flow_share[k] = (rate_sum > wrsa_pkg::SUM_BITS'(32'hFFFFFFFF)) ?
                            SW'(32'hFFFFFFFF) : SW'(rate_sum);
            expected_allocs.push_back(mk_res(wrsa_pkg::STS_OK, k, flow_share[k][31:0],
                                             1'b1));
          end else begin
            share_out_sum();
            for (int i = 0; i < wrsa_pkg::MAX_FLOWS; i++)
              if (flow_valid[i]) begin
                n++;
                expected_allocs.push_back(mk_res(wrsa_pkg::STS_OK, i, flow_share[i][31:0],
                                                 n == count));
              end
          end
        end
      end
    endcase
  endtask

  function automatic logic [31:0] rand_rate();
    case ($urandom_range(0, 5))
      0: return 32'hFFFFFFFF;
      1: return $urandom_range(0, 3);
      2: return $urandom_range(0, 1000);
      default: return $urandom;
    endcase
  endfunction

  function automatic flow_cmd_t rand_cmd(int mix);
    flow_cmd_t c;
    c.cc_rate = rand_rate();
    c.rate_cap = ($urandom_range(0, 3) == 0) ? 32'hFFFFFFFF : rand_rate();
    c.priority_req = ($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom);
    c.initial_rate = rand_rate();
    c.flow_slot = 3'($urandom);
    case ($urandom_range(0, 19) + mix)
      0, 1, 2, 3, 4, 5: c.command = wrsa_pkg::CMD_REGISTER;
      6, 7, 8: c.command = wrsa_pkg::CMD_UNREGISTER;
      9: c.command = wrsa_pkg::CMD_NONE;
      default: c.command = wrsa_pkg::CMD_UPDATE;
    endcase
    return c;
  endfunction

  function automatic flow_cmd_t dir_cmd(wrsa_pkg::cmd_t cmd, int slot, logic [31:0] cc,
                                        logic [31:0] cap, int prio,
                                        logic [31:0] init);
    flow_cmd_t c;
    c.command = cmd;
    c.flow_slot = slot[2:0];
    c.cc_rate = cc;
    c.rate_cap = cap;
    c.priority_req = 8'(prio);
    c.initial_rate = init;
    return c;
  endfunction

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pending_cmds.size() != 0 && !pause_sender &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        flow_cmd_t c;
        c = pending_cmds.pop_front();
        predict_allocs(c);
        in_valid <= 1'b1;
        in_command <= c.command;
        in_flow_slot <= c.flow_slot;
        in_cc_rate <= c.cc_rate;
        in_rate_cap <= c.rate_cap;
        in_priority_req <= c.priority_req;
        in_initial_rate <= c.initial_rate;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles <= cycles + 1;
    in_fire <= rst_n && in_valid && !in_stall;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_allocs.size() == 0) begin
        $error("unexpected result slot %0d", out_result_slot);
        errors++;
      end else begin
        alloc_res_t e;
        e = expected_allocs.pop_front();
        if (out_status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_status); errors++;
        end
        if (out_result_slot !== e.result_slot) begin
          $error("result_slot exp %0d got %0d", e.result_slot, out_result_slot); errors++;
        end
        if (out_allocated_rate !== e.allocated_rate) begin
          $error("allocated_rate exp %0d got %0d", e.allocated_rate, out_allocated_rate);
          errors++;
        end
        if (out_last !== e.last) begin
          $error("last exp %0d got %0d", e.last, out_last); errors++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_cmds.size() != 0 || in_valid || expected_allocs.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = wrsa_pkg::CMD_NONE;
    in_flow_slot = '0;
    in_cc_rate = '0;
    in_rate_cap = '0;
    in_priority_req = '0;
    in_initial_rate = '0;
    out_stall = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    pause_sender = 0;
    in_fire = 0;
    errors = 0;
    cycles = 0;
    for (int i = 0; i < wrsa_pkg::MAX_FLOWS; i++) begin
      flow_valid[i] = 1'b0;
      flow_prio[i] = '0;
      flow_share[i] = '0;
      flow_cap[i] = '0;
    end
    rate_sum = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: errors on empty table, single flow, saturation, full table
    pending_cmds.push_back(dir_cmd(wrsa_pkg::CMD_UNREGISTER, 7, 0, 0, 0, 0));
    pending_cmds.push_back(dir_cmd(wrsa_pkg::CMD_UPDATE, 0, 5, 5, 0, 0));
    pending_cmds.push_back(dir_cmd(wrsa_pkg::CMD_NONE, 3, 32'hFFFFFFFF, 32'hFFFFFFFF, 255,
                                   32'hFFFFFFFF));
    pending_cmds.push_back(dir_cmd(wrsa_pkg::CMD_REGISTER, 0, 0, 32'hFFFFFFFF, 255,
                                   32'hFFFFFFFF));
    pending_cmds.push_back(dir_cmd(wrsa_pkg::CMD_UPDATE, 0, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0));
    pending_cmds.push_back(dir_cmd(wrsa_pkg::CMD_UPDATE, 0, 0, 32'hFFFFFFFF, 0, 0));
    for (int i = 1; i < wrsa_pkg::MAX_FLOWS; i++)
      pending_cmds.push_back(dir_cmd(wrsa_pkg::CMD_REGISTER, 0, 0,
                                     (i == 3) ? 32'd100 : 32'hFFFFFFFF,
                                     (i == 2) ? 0 : i * 30, 32'(i * 1000)));
    pending_cmds.push_back(dir_cmd(wrsa_pkg::CMD_REGISTER, 0, 0, 1, 1, 1));
    pending_cmds.push_back(dir_cmd(wrsa_pkg::CMD_UPDATE, 3, 32'hFFFFFFFF, 32'd100, 0, 0));
    pending_cmds.push_back(dir_cmd(wrsa_pkg::CMD_UPDATE, 5, 0, 0, 0, 0));
    pending_cmds.push_back(dir_cmd(wrsa_pkg::CMD_UNREGISTER, 0, 0, 0, 0, 0));
    pending_cmds.push_back(dir_cmd(wrsa_pkg::CMD_UPDATE, 7, 32'h7FFFFFFF, 32'hFFFFFFFF, 0, 0));
    pending_cmds.push_back(dir_cmd(wrsa_pkg::CMD_UPDATE, 0, 0, 0, 0, 0));
    for (int i = 1; i < wrsa_pkg::MAX_FLOWS; i++)
      pending_cmds.push_back(dir_cmd(wrsa_pkg::CMD_UNREGISTER, i, 0, 0, 0, 0));
    wait_drained();

    // random phases with different idle patterns
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 76 : 16) : 0;
      recv_stall_pct = (ph == 2) ? 76 : ((ph == 3) ? 16 : 0);
      for (int n = 0; n < 40; n++)
        pending_cmds.push_back(rand_cmd((ph == 0) ? 0 : 3));
      if (ph == 2) begin
        hold_cycles = 3000;
      end
      wait_drained();
      if (ph == 1) begin
        pause_sender = 1;
        repeat (50) @(posedge clk);
        pause_sender = 0;
      end
    end

    repeat (200) @(posedge clk);
    if (errors == 0 && expected_allocs.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
